/* hw/rtl/lfu_pkg.sv */
package lfu_pkg;

  localparam int DEPTH      = 16;
  localparam int COUNT_BITS = 16;
  localparam int KEY_W      = 32;
  localparam int CAP_W      = 5;
  localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int OCC_W      = $clog2(DEPTH + 1);
  localparam logic [CAP_W-1:0]      CAP_RESET = CAP_W'(16);
  localparam logic [COUNT_BITS-1:0] CNT_MAX   = {COUNT_BITS{1'b1}};

  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_SCAN,
    ST_MOVE,
    ST_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic step;
    logic take_hit;
    logic take_ins;
    logic scan_mode;
    logic scan_step;
    logic move;
    logic emit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic srch_match;
    logic srch_end;
    logic do_ins;
    logic scan_end;
    logic out_free;
  } stat_t;

endpackage

/* hw/rtl/lfu_cache_lru_tiebreak.sv */
// LFU key-value cache, ties broken toward the least recently touched entry.
// Input stream: one beat is a get or a put. in_tuser carries the opcode,
// in_tdata the key and the value. Output stream: one beat per input beat,
// in order, with hit and evicted flags in out_tuser and the read value and
// evicted key in out_tdata. cfg_valid/cfg_ready write the capacity limit;
// write it only while the cache is idle.
// Throughput: one item at a time. An item steps through the linear search
// over the ranked entries (up to DEPTH of them), the scan toward the front
// for its new rank (up to DEPTH - 1 entries), the move into that rank, and
// the result beat. A get miss, or a put with a zero capacity limit, skips
// the scan and the move. The block is ready for the next item in the cycle
// after the result is loaded. One read port into the ranked entry table
// makes the search and the scan go entry by entry.
// Reset empties the cache and sets the capacity limit to 16.
// If the receiver stalls, the result beat holds in the output register. The
// block still takes the next item and works it up to that register, then
// waits and takes no further item until the held beat has left.
module lfu_cache_lru_tiebreak (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [31:0] lookup_key, [63:32] write_value
  input  logic [0:0]  in_tuser,   // [0] opcode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [31:0] read_value, [63:32] evicted_key
  output logic [1:0]  out_tuser,  // [0] hit, [1] evicted
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [4:0]  cfg_data
);

  lfu_pkg::cmd_t  cmd;
  lfu_pkg::stat_t stat;

  assign cfg_ready = 1'b1;

  lfu_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  lfu_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_op     (in_tuser[0]),
    .in_key    (in_tdata[31:0]),
    .in_val    (in_tdata[63:32]),
    .cfg_we    (cfg_valid),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_hit   (out_tuser[0]),
    .out_rd    (out_tdata[31:0]),
    .out_ev    (out_tuser[1]),
    .out_evk   (out_tdata[63:32])
  );

endmodule

/* hw/rtl/lfu_ctrl.sv */
module lfu_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  lfu_pkg::stat_t stat,
  output lfu_pkg::cmd_t  cmd
);

  lfu_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lfu_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lfu_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = lfu_pkg::ST_SEARCH;
      end
      lfu_pkg::ST_SEARCH: begin
        if (stat.srch_match) begin
          state_nxt = lfu_pkg::ST_SCAN;
        end else if (stat.srch_end) begin
          state_nxt = stat.do_ins ? lfu_pkg::ST_SCAN : lfu_pkg::ST_DONE;
        end
      end
      lfu_pkg::ST_SCAN: begin
        if (stat.scan_end) state_nxt = lfu_pkg::ST_MOVE;
      end
      lfu_pkg::ST_MOVE: state_nxt = lfu_pkg::ST_DONE;
      lfu_pkg::ST_DONE: begin
        if (stat.out_free) state_nxt = lfu_pkg::ST_IDLE;
      end
      default: state_nxt = lfu_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      lfu_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      lfu_pkg::ST_SEARCH: begin
        if (stat.srch_match) begin
          cmd.take_hit = 1'b1;
        end else if (stat.srch_end) begin
          cmd.take_ins = stat.do_ins;
        end else begin
          cmd.step = 1'b1;
        end
      end
      lfu_pkg::ST_SCAN: begin
        cmd.scan_mode = 1'b1;
        cmd.scan_step = !stat.scan_end;
      end
      lfu_pkg::ST_MOVE: cmd.move = 1'b1;
      lfu_pkg::ST_DONE: cmd.emit = stat.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

/* hw/rtl/lfu_dp.sv */
module lfu_dp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_op,
  input  logic [lfu_pkg::KEY_W-1:0]   in_key,
  input  logic [lfu_pkg::KEY_W-1:0]   in_val,
  input  logic                        cfg_we,
  input  logic [lfu_pkg::CAP_W-1:0]   cfg_data,
  input  lfu_pkg::cmd_t               cmd,
  output lfu_pkg::stat_t              stat,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_hit,
  output logic [lfu_pkg::KEY_W-1:0]   out_rd,
  output logic                        out_ev,
  output logic [lfu_pkg::KEY_W-1:0]   out_evk
);

  // entries held in rank order, position 0 ranks highest
  logic [lfu_pkg::KEY_W-1:0]      key_a [lfu_pkg::DEPTH];
  logic [lfu_pkg::KEY_W-1:0]      val_a [lfu_pkg::DEPTH];
  logic [lfu_pkg::COUNT_BITS-1:0] cnt_a [lfu_pkg::DEPTH];

  logic [lfu_pkg::OCC_W-1:0]      occ_r, idx_r, q_r, pos_r;
  logic [lfu_pkg::CAP_W-1:0]      cap_r;
  logic                           op_r, hit_r, ev_r, ins_r, ovld_r;
  logic [lfu_pkg::KEY_W-1:0]      key_r, val_r, tv_r, rd_r, evk_r, lastk_r;
  logic [lfu_pkg::COUNT_BITS-1:0] c_r;
  logic                           o_hit_r, o_ev_r;
  logic [lfu_pkg::KEY_W-1:0]      o_rd_r, o_evk_r;

  logic [lfu_pkg::OCC_W-1:0]      qm1, lim;
  logic [lfu_pkg::IDX_W-1:0]      rd_addr;
  logic [lfu_pkg::KEY_W-1:0]      rd_key, rd_val;
  logic [lfu_pkg::COUNT_BITS-1:0] rd_cnt, cnt_bump;
  logic                           evict;

  assign qm1     = q_r - 1'b1;
  assign rd_addr = cmd.scan_mode ? qm1[lfu_pkg::IDX_W-1:0] : idx_r[lfu_pkg::IDX_W-1:0];
  assign rd_key  = key_a[rd_addr];
  assign rd_val  = val_a[rd_addr];
  assign rd_cnt  = cnt_a[rd_addr];
  assign cnt_bump = (rd_cnt == lfu_pkg::CNT_MAX) ? rd_cnt : rd_cnt + 1'b1;

  assign lim   = (32'(cap_r) > lfu_pkg::DEPTH) ? lfu_pkg::OCC_W'(lfu_pkg::DEPTH)
                                                : lfu_pkg::OCC_W'(cap_r);
  assign evict = (occ_r >= lim);

  assign stat.srch_match = (idx_r < occ_r) && (rd_key == key_r);
  assign stat.srch_end   = (idx_r == occ_r);
  assign stat.do_ins     = (op_r == lfu_pkg::OP_PUT) && (lim != '0);
  assign stat.scan_end   = (q_r == '0) || (rd_cnt > c_r);
  assign stat.out_free   = !ovld_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r  <= '0;
      cap_r  <= lfu_pkg::CAP_RESET;
      ovld_r <= 1'b0;
    end else begin
      if (cfg_we) cap_r <= cfg_data;
      if (cmd.take_ins && evict) begin
        occ_r <= occ_r - 1'b1;
      end else if (cmd.move && ins_r) begin
        occ_r <= occ_r + 1'b1;
      end
      if (cmd.emit) begin
        ovld_r <= 1'b1;
      end else if (out_ready) begin
        ovld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= in_op;
      key_r <= in_key;
      val_r <= in_val;
      idx_r <= '0;
      hit_r <= 1'b0;
      ev_r  <= 1'b0;
      ins_r <= 1'b0;
      rd_r  <= '0;
      evk_r <= '0;
    end
    if (cmd.step) begin
      idx_r   <= idx_r + 1'b1;
      lastk_r <= rd_key;
    end
    if (cmd.take_hit) begin
      hit_r <= 1'b1;
      pos_r <= idx_r;
      q_r   <= idx_r;
      c_r   <= cnt_bump;
      tv_r  <= (op_r == lfu_pkg::OP_PUT) ? val_r : rd_val;
      rd_r  <= (op_r == lfu_pkg::OP_PUT) ? '0 : rd_val;
    end
    if (cmd.take_ins) begin
      ins_r <= 1'b1;
      tv_r  <= val_r;
      c_r   <= lfu_pkg::COUNT_BITS'(1);
      // drop the lowest-ranked entry and reuse its position
      if (evict) begin
        ev_r  <= 1'b1;
        evk_r <= lastk_r;
        pos_r <= occ_r - 1'b1;
        q_r   <= occ_r - 1'b1;
      end else begin
        pos_r <= occ_r;
        q_r   <= occ_r;
      end
    end
    if (cmd.scan_step) q_r <= qm1;
    if (cmd.emit) begin
      o_hit_r <= hit_r;
      o_rd_r  <= rd_r;
      o_ev_r  <= ev_r;
      o_evk_r <= evk_r;
    end
  end

  // shift the run between the new rank and the old one down by one
  always_ff @(posedge clk) begin
    if (cmd.move) begin
      for (int i = 0; i < lfu_pkg::DEPTH; i++) begin
        if (lfu_pkg::OCC_W'(i) == q_r) begin
          key_a[i] <= key_r;
          val_a[i] <= tv_r;
          cnt_a[i] <= c_r;
        end else if (i > 0 && lfu_pkg::OCC_W'(i) > q_r && lfu_pkg::OCC_W'(i) <= pos_r) begin
          key_a[i] <= key_a[(i > 0) ? i - 1 : 0];
          val_a[i] <= val_a[(i > 0) ? i - 1 : 0];
          cnt_a[i] <= cnt_a[(i > 0) ? i - 1 : 0];
        end
      end
    end
  end

  assign out_valid = ovld_r;
  assign out_hit   = o_hit_r;
  assign out_rd    = o_rd_r;
  assign out_ev    = o_ev_r;
  assign out_evk   = o_evk_r;

endmodule

/* hw/rtl/lfu_chk.sv */
module lfu_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [63:0] out_tdata,
  input logic [1:0]  out_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser))
    else $error("result beat changed while stalled");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second item taken while one is in work");

  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tuser[0] && out_tuser[1]))
    else $error("hit and eviction on the same item");

  a_evk_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[1] |-> out_tdata[63:32] == 32'd0)
    else $error("evicted key set without eviction");

endmodule

bind lfu_cache_lru_tiebreak lfu_chk u_lfu_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

/* test/lfu_cache_checker.sv */
`timescale 1ns / 100ps

module lfu_cache_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [63:0] in_tdata,
  input  logic [0:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [63:0] out_tdata,
  input  logic [1:0]  out_tuser,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [4:0]  cfg_data,
  output int          fail_count,
  output int          pending_results
);

  typedef struct packed {
    logic        hit;
    logic [31:0] read_value;
    logic        evicted;
    logic [31:0] evicted_key;
  } lookup_result_t;

  lookup_result_t expected_results[$];

  logic [lfu_pkg::CAP_W-1:0]      cap_limit;
  logic                           slot_valid[lfu_pkg::DEPTH];
  logic [31:0]                    slot_key[lfu_pkg::DEPTH];
  logic [31:0]                    slot_value[lfu_pkg::DEPTH];
  logic [lfu_pkg::COUNT_BITS-1:0] slot_count[lfu_pkg::DEPTH];
  int                             rank_slot[lfu_pkg::DEPTH];
  int                             live_entries;

  assign pending_results = expected_results.size();

  // Move the entry at rank pos ahead of every earlier entry with count <= its own.
  function automatic void raise_rank(int pos);
    int s;
    int q;
    s = rank_slot[pos];
    q = pos;
    while (q > 0 && slot_count[rank_slot[q-1]] <= slot_count[s]) q--;
    for (int p = pos; p > q; p--) rank_slot[p] = rank_slot[p-1];
    rank_slot[q] = s;
  endfunction

  function automatic lookup_result_t cache_access(logic op, logic [31:0] key,
                                                  logic [31:0] val);
    lookup_result_t r;
    int lim;
    int pos;
    int s;
    int fresh;
    r = '0;
    lim = (cap_limit > lfu_pkg::DEPTH) ? lfu_pkg::DEPTH : int'(cap_limit);
    pos = -1;
    for (int i = 0; i < live_entries; i++)
      if (pos < 0 && slot_valid[rank_slot[i]] && slot_key[rank_slot[i]] == key) pos = i;
    if (pos >= 0) begin
      s = rank_slot[pos];
      r.hit = 1'b1;
      if (op == lfu_pkg::OP_GET) r.read_value = slot_value[s];
      else slot_value[s] = val;
      if (slot_count[s] != lfu_pkg::CNT_MAX) slot_count[s]++;
      raise_rank(pos);
    end else if (op == lfu_pkg::OP_PUT && lim > 0) begin
      if (live_entries >= lim) begin
        s = rank_slot[live_entries-1];
        r.evicted = 1'b1;
        r.evicted_key = slot_key[s];
        slot_valid[s] = 1'b0;
        live_entries--;
      end
      fresh = -1;
      for (int i = 0; i < lfu_pkg::DEPTH; i++)
        if (fresh < 0 && !slot_valid[i]) fresh = i;
      if (fresh >= 0) begin
        slot_valid[fresh] = 1'b1;
        slot_key[fresh] = key;
        slot_value[fresh] = val;
        slot_count[fresh] = 1;
        rank_slot[live_entries] = fresh;
        live_entries++;
        raise_rank(live_entries - 1);
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    lookup_result_t got;
    lookup_result_t want;
    if (!rst_n) begin
      cap_limit <= lfu_pkg::CAP_RESET;
      live_entries = 0;
      for (int i = 0; i < lfu_pkg::DEPTH; i++) slot_valid[i] = 1'b0;
      expected_results.delete();
      fail_count <= 0;
    end else begin
      if (cfg_valid && cfg_ready) cap_limit <= cfg_data;
      if (in_tvalid && in_tready)
        expected_results.push_back(cache_access(in_tuser[0], in_tdata[31:0],
                                                in_tdata[63:32]));
      if (out_tvalid && out_tready) begin
        got = {out_tuser[0], out_tdata[31:0], out_tuser[1], out_tdata[63:32]};
        if (expected_results.size() == 0) begin
          $error("result beat with nothing expected");
          fail_count <= fail_count + 1;
        end else begin
          want = expected_results.pop_front();
          if (got != want) fail_count <= fail_count + 1;
          if (got.hit != want.hit)
            $error("hit: expected %0d, got %0d", want.hit, got.hit);
          if (got.read_value != want.read_value)
            $error("read_value: expected %h, got %h", want.read_value, got.read_value);
          if (got.evicted != want.evicted)
            $error("evicted: expected %0d, got %0d", want.evicted, got.evicted);
          if (got.evicted_key != want.evicted_key)
            $error("evicted_key: expected %h, got %h", want.evicted_key,
                   got.evicted_key);
        end
      end
    end
  end
endmodule

/* test/tb_lfu_cache_lru_tiebreak.sv */
`timescale 1ns / 100ps

module tb_lfu_cache_lru_tiebreak;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;
  logic [0:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [63:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [4:0]  cfg_data;
  int          fail_count;
  int          pending_results;
  int          cycle_count;
  int          send_idle_pct;
  int          recv_stall_pct;
  logic [31:0] key_pool[24];

  localparam int CYCLE_LIMIT = 800000;

  lfu_cache_lru_tiebreak dut (.*);

  lfu_cache_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(posedge clk)
    out_tready <= ($urandom_range(99) >= recv_stall_pct);

  // valid stays high between back-to-back beats; drop it only while idling
  task automatic send_beat(logic op, logic [31:0] key, logic [31:0] val);
    if ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {val, key};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (2 * lfu_pkg::DEPTH + 8) @(posedge clk);
  endtask

  task automatic set_capacity(logic [4:0] cap);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data  <= cap;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [31:0] pick_key();
    return ($urandom_range(9) == 0) ? $urandom() : key_pool[$urandom_range(23)];
  endfunction

  task automatic random_burst(int count);
    int r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      send_beat(r < 45 ? lfu_pkg::OP_PUT : lfu_pkg::OP_GET, pick_key(), $urandom());
      // hammer one key so its count climbs and ties break differently
      if (r < 8)
        repeat ($urandom_range(6)) send_beat(lfu_pkg::OP_GET, key_pool[0], $urandom());
    end
  endtask

  initial begin
    logic [4:0] caps[7];
    caps = '{5'd3, 5'd16, 5'd31, 5'd1, 5'd0, 5'd8, 5'd17};
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    out_tready = 1'b1;
    cycle_count = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    for (int i = 0; i < 24; i++) key_pool[i] = $urandom();
    key_pool[0] = 32'h8000_0000;
    key_pool[1] = 32'h7FFF_FFFF;
    key_pool[2] = 32'hFFFF_FFFF;
    key_pool[3] = 32'h0000_0000;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty get, extremes, update, tie order, eviction
    send_beat(lfu_pkg::OP_GET, 32'h0, 32'hFFFF_FFFF);
    send_beat(lfu_pkg::OP_PUT, 32'h8000_0000, 32'hFFFF_FFFF);
    send_beat(lfu_pkg::OP_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
    send_beat(lfu_pkg::OP_GET, 32'h8000_0000, 32'h0);
    send_beat(lfu_pkg::OP_PUT, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_beat(lfu_pkg::OP_GET, 32'h7FFF_FFFF, 32'h0);
    send_beat(lfu_pkg::OP_GET, 32'hFFFF_FFFF, 32'h0);
    set_capacity(5'd2);
    send_beat(lfu_pkg::OP_PUT, 32'h0000_0000, 32'h1234_5678);
    send_beat(lfu_pkg::OP_PUT, 32'hFFFF_FFFF, 32'h5555_AAAA);
    send_beat(lfu_pkg::OP_GET, 32'hFFFF_FFFF, 32'h0);
    // capacity zero: puts do nothing, gets still hit
    set_capacity(5'd0);
    send_beat(lfu_pkg::OP_PUT, 32'hAAAA_5555, 32'h1);
    send_beat(lfu_pkg::OP_GET, 32'hFFFF_FFFF, 32'h0);
    send_beat(lfu_pkg::OP_GET, 32'hAAAA_5555, 32'h0);
    // fill all, then shrink below occupancy
    set_capacity(5'd31);
    for (int i = 0; i < 18; i++) send_beat(lfu_pkg::OP_PUT, key_pool[i], $urandom());
    set_capacity(5'd4);
    send_beat(lfu_pkg::OP_PUT, 32'h0BAD_F00D, 32'h2);
    send_beat(lfu_pkg::OP_GET, key_pool[5], 32'h0);

    // one hot key climbing past everything else
    set_capacity(5'd16);
    send_beat(lfu_pkg::OP_PUT, 32'h5A5A_5A5A, 32'h3);
    for (int i = 0; i < 20; i++) send_beat(lfu_pkg::OP_GET, 32'h5A5A_5A5A, 32'h0);
    send_beat(lfu_pkg::OP_PUT, 32'h5A5A_5A5A, 32'h4);

    for (int ph = 0; ph < 7; ph++) begin
      set_capacity(caps[ph]);
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 71; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 71; end
        default: begin send_idle_pct = 26; recv_stall_pct = 26; end
      endcase
      random_burst(150);
      // let the pipeline empty mid-phase
      drain_results();
      random_burst(60);
    end

    drain_results();
    repeat (10) @(posedge clk);
    if (fail_count == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end
endmodule

/* lfu_cache_lru_tiebreak.f */
hw/rtl/lfu_pkg.sv
hw/rtl/lfu_ctrl.sv
hw/rtl/lfu_dp.sv
hw/rtl/lfu_cache_lru_tiebreak.sv
hw/rtl/lfu_chk.sv
test/lfu_cache_checker.sv
test/tb_lfu_cache_lru_tiebreak.sv
